// ===== rtl/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the 4x4 fixed-point matrix product engine.
// ----------------------------------------------------------------------------
package mvt_pkg;

	// Fixed-point format of every element: signed Q(32-FRAC_BITS).FRAC_BITS.
	localparam int unsigned ELEM_W    = 32;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned DIM       = 4;
	localparam int unsigned IDX_W     = $clog2(DIM);

	// A product is exact; the sum of four products needs two guard bits.
	localparam int unsigned PROD_W = 2 * ELEM_W;
	localparam int unsigned SUM_W  = PROD_W + 2;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef enum logic {
		OP_LOAD      = 1'b0,
		OP_TRANSFORM = 1'b1
	} op_t;

	// Command word: one column, either for the store or to be transformed.
	typedef struct packed {
		op_t              operation;
		logic [IDX_W-1:0] column_index;
		elem_t            in_e0;
		elem_t            in_e1;
		elem_t            in_e2;
		elem_t            in_e3;
	} cmd_word_t;

	// Result word: one saturated result column.
	typedef struct packed {
		elem_t out_e0;
		elem_t out_e1;
		elem_t out_e2;
		elem_t out_e3;
	} res_word_t;

endpackage

// ===== rtl/mvt_cmd_if.sv =====
// ----------------------------------------------------------------------------
// mvt_cmd_if
// Valid/ready channel that carries command words into the engine.
// ----------------------------------------------------------------------------
interface mvt_cmd_if;
	import mvt_pkg::*;

	logic      valid;
	logic      ready;
	cmd_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/mvt_res_if.sv =====
// ----------------------------------------------------------------------------
// mvt_res_if
// Valid/ready channel that carries result words out of the engine.
// ----------------------------------------------------------------------------
interface mvt_res_if;
	import mvt_pkg::*;

	logic      valid;
	logic      ready;
	res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/mat4_vector_transform.sv =====
// ----------------------------------------------------------------------------
// mat4_vector_transform
// 4x4 signed fixed-point matrix product engine, column-major. Load words
// write one column of the stored left matrix; transform words carry one
// column of the right matrix and return the product column, saturated.
//
// Channel  Dir  Handshake    Word
// cmd      in   valid/ready  operation, column_index, in_e0..in_e3
// res      out  valid/ready  out_e0..out_e3
//
// One word is accepted per cycle while the pipeline is not backed up by a
// stalled result side. A transform word passes through the input register,
// sixteen parallel 32x32 multipliers, four-term adder trees, then shift and
// saturation into the result register. Load words update the store as they
// leave the input register. Each stage holds while the stage after it is
// full and stalled, so bubbles are squeezed out and nothing is lost or repeated.
// Reset clears the valid bits and the stored matrix to zero.
// ----------------------------------------------------------------------------
module mat4_vector_transform (
	input  logic      clk,
	input  logic      arst_n,
	mvt_cmd_if.sink   cmd,
	mvt_res_if.source res
);
	import mvt_pkg::*;

	localparam int unsigned SH_W = SUM_W - FRAC_BITS;

	// Stored left matrix: entry k*DIM+j is element j of column k.
	elem_t mat_q [DIM*DIM];

	// Stage registers.
	logic                  v_s1, v_s2, v_s3, v_s4;
	op_t                   op_s1;
	logic [IDX_W-1:0]      col_s1;
	elem_t                 e_s1 [DIM];
	logic signed [PROD_W-1:0] p_s2 [DIM][DIM];
	logic signed [SUM_W-1:0]  sum_s3 [DIM];
	elem_t                 out_s4 [DIM];

	logic en1, en2, en3, en4;

	// Stage enables: a stage moves when it is empty or its successor moves.
	assign en4 = !v_s4 || res.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign cmd.ready = en1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && cmd.valid) begin
			op_s1  <= cmd.data.operation;
			col_s1 <= cmd.data.column_index;
			e_s1[0] <= cmd.data.in_e0;
			e_s1[1] <= cmd.data.in_e1;
			e_s1[2] <= cmd.data.in_e2;
			e_s1[3] <= cmd.data.in_e3;
		end
	end

	// Matrix store: a load word writes its column as it leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM*DIM; i++) begin
				mat_q[i] <= '0;
			end
		end else if (v_s1 && en2 && op_s1 == OP_LOAD) begin
			for (int j = 0; j < DIM; j++) begin
				mat_q[{col_s1, IDX_W'(j)}] <= e_s1[j];
			end
		end
	end

	// Multiplier stage: lane j, term k is left[k][j] times element k.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1 && op_s1 == OP_TRANSFORM;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1 && op_s1 == OP_TRANSFORM) begin
			for (int j = 0; j < DIM; j++) begin
				for (int k = 0; k < DIM; k++) begin
					p_s2[j][k] <= PROD_W'(mat_q[{IDX_W'(k), IDX_W'(j)}])
						* PROD_W'(e_s1[k]);
				end
			end
		end
	end

	// Adder stage: exact four-term sum in each lane.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			for (int j = 0; j < DIM; j++) begin
				sum_s3[j] <= SUM_W'(p_s2[j][0]) + SUM_W'(p_s2[j][1])
					+ SUM_W'(p_s2[j][2]) + SUM_W'(p_s2[j][3]);
			end
		end
	end

	// Shift with floor rounding, then saturate to the element range.
	logic signed [SH_W-1:0] sh    [DIM];
	elem_t                  sat_c [DIM];

	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			sh[j] = SH_W'(sum_s3[j] >>> FRAC_BITS);
			if (!sh[j][SH_W-1] && (|sh[j][SH_W-2:ELEM_W-1])) begin
				sat_c[j] = {1'b0, {(ELEM_W-1){1'b1}}};
			end else if (sh[j][SH_W-1] && !(&sh[j][SH_W-2:ELEM_W-1])) begin
				sat_c[j] = {1'b1, {(ELEM_W-1){1'b0}}};
			end else begin
				sat_c[j] = sh[j][ELEM_W-1:0];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			for (int j = 0; j < DIM; j++) begin
				out_s4[j] <= sat_c[j];
			end
		end
	end

	assign res.valid       = v_s4;
	assign res.data.out_e0 = out_s4[0];
	assign res.data.out_e1 = out_s4[1];
	assign res.data.out_e2 = out_s4[2];
	assign res.data.out_e3 = out_s4[3];

endmodule

// ===== rtl/mvt_checker.sv =====
// ----------------------------------------------------------------------------
// mvt_checker
// Port-level checks of the matrix product engine, bound to the top level.
// ----------------------------------------------------------------------------
module mvt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input mvt_pkg::op_t      in_op,
	input logic              out_valid,
	input logic              out_ready,
	input mvt_pkg::res_word_t out_data
);
	import mvt_pkg::*;

	logic tf_acc;

	assign tf_acc = in_valid && in_ready && in_op == OP_TRANSFORM;

	// A stalled result word stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid && !out_ready) |-> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its value.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid && !out_ready) |-> $stable(out_data))
		else $error("result word changed while stalled");

	// With the result register free to move, the pipeline takes a word.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input refused while the pipeline can advance");

	// An accepted transform word reaches the result port when nothing stalls.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(tf_acc, 4) && $past(out_ready, 3) && $past(out_ready, 2)
		&& $past(out_ready, 1) && $past(arst_n, 4) |-> out_valid)
		else $error("transform result missing after pipeline latency");

endmodule

bind mat4_vector_transform mvt_checker u_mvt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd.valid),
	.in_ready  (cmd.ready),
	.in_op     (cmd.data.operation),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_data  (res.data)
);

// ===== verif/mat4_vector_transform_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_vector_transform_tb
// Self-checking bench for the 4x4 fixed-point matrix product engine. Command
// words are driven in random bursts while the result side stalls on its own
// pattern. A scoreboard keeps a copy of the stored matrix, predicts every
// result column in full-width signed arithmetic and checks each result word
// against the oldest prediction.
// ----------------------------------------------------------------------------
module mat4_vector_transform_tb;
	import mvt_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 950;

	// Saturation bounds at the width of the four-term sum.
	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	// Scoreboard: mirrors the stored left matrix and queues predicted columns.
	class column_product_board;
		elem_t       left_store [DIM*DIM];
		res_word_t   expected_cols [$];
		int unsigned mismatches;

		function new();
			foreach (left_store[i])
				left_store[i] = '0;
			mismatches = 0;
		endfunction

		// Product of the stored matrix with one right-hand column.
		function res_word_t product_column(elem_t v [DIM]);
			logic signed [SUM_W-1:0]  acc;
			logic signed [PROD_W-1:0] prod;
			logic signed [SUM_W-1:0]  scaled;
			elem_t                    col [DIM];
			res_word_t                r;
			for (int j = 0; j < DIM; j++) begin
				acc = '0;
				for (int k = 0; k < DIM; k++) begin
					prod = PROD_W'(left_store[k*DIM + j]) * PROD_W'(v[k]);
					acc  = acc + SUM_W'(prod);
				end
				// Arithmetic shift floors; then clamp to the 32-bit range.
				scaled = acc >>> FRAC_BITS;
				if (scaled > SAT_HI)
					col[j] = SAT_HI[ELEM_W-1:0];
				else if (scaled < SAT_LO)
					col[j] = SAT_LO[ELEM_W-1:0];
				else
					col[j] = scaled[ELEM_W-1:0];
			end
			r.out_e0 = col[0];
			r.out_e1 = col[1];
			r.out_e2 = col[2];
			r.out_e3 = col[3];
			return r;
		endfunction

		// An accepted command word either updates the store or adds a prediction.
		function void note_command(cmd_word_t w);
			elem_t v [DIM];
			v = '{w.in_e0, w.in_e1, w.in_e2, w.in_e3};
			if (w.operation == OP_LOAD) begin
				for (int j = 0; j < DIM; j++)
					left_store[int'(w.column_index)*DIM + j] = v[j];
			end else begin
				expected_cols.push_back(product_column(v));
			end
		endfunction

		function void check_result(res_word_t got);
			res_word_t want;
			elem_t     g [DIM];
			elem_t     e [DIM];
			if (expected_cols.size() == 0) begin
				mismatches++;
				$display("%0t: result word expected none actual %h", $time, got);
				return;
			end
			want = expected_cols.pop_front();
			g = '{got.out_e0, got.out_e1, got.out_e2, got.out_e3};
			e = '{want.out_e0, want.out_e1, want.out_e2, want.out_e3};
			for (int j = 0; j < DIM; j++) begin
				if (g[j] !== e[j]) begin
					mismatches++;
					$display("%0t: out_e%0d expected %h actual %h", $time, j, e[j], g[j]);
				end
			end
		endfunction

		function int unsigned outstanding();
			return expected_cols.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mvt_cmd_if cmd_ch ();
	mvt_res_if res_ch ();

	mat4_vector_transform u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	column_product_board board;
	int                  burst_left;
	int                  ready_mode  = 0;
	int                  ready_phase = 0;
	int                  cycle_count = 0;

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit, well beyond the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("mat4_vector_transform regression: fail");
			$finish;
		end
	end

	function automatic cmd_word_t build_word(input op_t op, input logic [IDX_W-1:0] col,
			input elem_t e0, input elem_t e1, input elem_t e2, input elem_t e3);
		cmd_word_t w;
		w.operation    = op;
		w.column_index = col;
		w.in_e0        = e0;
		w.in_e1        = e1;
		w.in_e2        = e2;
		w.in_e3        = e3;
		return w;
	endfunction

	// Element values: full range, moderate magnitudes, corners and fractions.
	function automatic elem_t rand_elem(input bit small_only);
		int    pick;
		int    s;
		elem_t corner_vals [7];
		corner_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001};
		pick = small_only ? 1 : $urandom_range(0, 5);
		case (pick)
			1: begin
				s = $urandom_range(0, 524288);
				return elem_t'(s - 262144);
			end
			2: return corner_vals[$urandom_range(0, 6)];
			3: begin
				s = $urandom_range(0, 65535);
				return elem_t'(s - 32768);
			end
			default: return elem_t'($urandom);
		endcase
	endfunction

	// Drive one command word, with random gaps between bursts.
	task automatic send_word(input cmd_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= w;
		do @(posedge clk); while (!cmd_ch.ready);
		board.note_command(w);
	endtask

	// Result side: check accepted words, and stall on a changing pattern.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			board.check_result(res_ch.data);
		if (ready_phase == 0) begin
			ready_mode  = $urandom_range(0, 3);
			ready_phase = $urandom_range(16, 96);
		end else begin
			ready_phase--;
		end
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			case (ready_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= ($urandom_range(0, 3) == 0);
				default: res_ch.ready <= (ready_phase % 32 == 0);
			endcase
		end
	end

	initial begin
		int cols [DIM];
		int sent;
		int n;
		int t;
		int sel;
		bit small_only;

		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		burst_left   = 0;
		board        = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Transform against the cleared store.
		send_word(build_word(OP_TRANSFORM, 2'd2, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000));
		// Identity matrix, columns written in reverse order.
		send_word(build_word(OP_LOAD, 2'd3, 0, 0, 0, 32'h0001_0000));
		send_word(build_word(OP_LOAD, 2'd2, 0, 0, 32'h0001_0000, 0));
		send_word(build_word(OP_LOAD, 2'd1, 0, 32'h0001_0000, 0, 0));
		send_word(build_word(OP_LOAD, 2'd0, 32'h0001_0000, 0, 0, 0));
		// Column index is ignored on a transform.
		send_word(build_word(OP_TRANSFORM, 2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 0, -1));
		send_word(build_word(OP_TRANSFORM, 2'd1, 32'h0001_8000, 32'hFFFD_C000,
			32'h0000_C000, 32'hFFFF_FFFF));
		// Saturation at both ends from one large column.
		send_word(build_word(OP_LOAD, 2'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_word(build_word(OP_TRANSFORM, 2'd0, 0, 0, 32'h7FFF_FFFF, 0));
		send_word(build_word(OP_TRANSFORM, 2'd0, 0, 0, 32'h8000_0000, 0));
		// Largest magnitude sums: all four products at their extremes.
		for (int c = 0; c < DIM; c++)
			send_word(build_word(OP_LOAD, 2'(c), 32'h8000_0000, 32'h8000_0000,
				32'h8000_0000, 32'h8000_0000));
		send_word(build_word(OP_TRANSFORM, 2'd0, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000));
		send_word(build_word(OP_TRANSFORM, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF));
		// Negative fractional remainders must floor to minus one.
		send_word(build_word(OP_LOAD, 2'd0, 1, 1, 1, 1));
		for (int c = 1; c < DIM; c++)
			send_word(build_word(OP_LOAD, 2'(c), 0, 0, 0, 0));
		send_word(build_word(OP_TRANSFORM, 2'd0, -32768, 0, 0, 0));
		send_word(build_word(OP_TRANSFORM, 2'd0, -1, 0, 0, 0));

		// Random part: mostly full products (four loads, four transforms),
		// with runs of loose words in between.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				small_only = ($urandom_range(0, 1) == 0);
				cols = '{0, 1, 2, 3};
				for (int i = DIM - 1; i > 0; i--) begin
					n = $urandom_range(0, i);
					t = cols[i];
					cols[i] = cols[n];
					cols[n] = t;
				end
				for (int i = 0; i < DIM; i++)
					send_word(build_word(OP_LOAD, 2'(cols[i]), rand_elem(small_only),
						rand_elem(small_only), rand_elem(small_only), rand_elem(small_only)));
				for (int i = 0; i < DIM; i++)
					send_word(build_word(OP_TRANSFORM, 2'($urandom_range(0, 3)),
						rand_elem(small_only), rand_elem(small_only),
						rand_elem(small_only), rand_elem(small_only)));
				sent += 2 * DIM;
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					send_word(build_word(op_t'($urandom_range(0, 1)),
						2'($urandom_range(0, 3)), rand_elem(1'b0), rand_elem(1'b0),
						rand_elem(1'b0), rand_elem(1'b0)));
				sent += n;
			end
		end
		cmd_ch.valid <= 1'b0;

		// Drain, then allow for the pipeline depth before the verdict.
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("mat4_vector_transform regression: pass");
		else
			$display("mat4_vector_transform regression: fail");
		$finish;
	end

endmodule
